// ----- hw/rtl/slid_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list package
// Types and constants shared by the sorted insert/delete store.
// ----------------------------------------------------------------------------
package slid_pkg;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FIELD_W  = 7;

   // Request type encoding on req_type.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 2'd0,
      ST_DELETED   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } slid_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMPARE,
      S_APPLY
   } slid_state_type;

   // Shift command broadcast to every cell.
   typedef struct packed {
      logic ins;
      logic del;
   } slid_shift_type;

endpackage

// ----- hw/rtl/slid_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface slid_req_if import slid_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface slid_rsp_if import slid_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [FIELD_W-1:0]  position;
   logic [FIELD_W-1:0]  occupancy;

   modport source (output valid, output status, output position, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input position, input occupancy,
                   output ready);
endinterface

// ----- hw/rtl/sorted_list_insert_delete.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list insert/delete store
// Keeps up to DEPTH signed values in ascending order in a row of cells and
// answers each insert or delete request with status, position and occupancy.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload
//   -------  ---------  ----------------------------------------------
//   req_ch   in         req_type (0 insert, 1 delete), value (signed 32)
//   rsp_ch   out        status (2 bits), position and occupancy (7 bits each)
//
// Each request passes an accept cycle, which latches the request, a compare
// cycle, where every cell registers whether its entry is below or equal to
// the value, and an apply cycle that shifts the cells and loads the response.
// Reset is synchronous and active high; it clears the occupancy count and
// the control state, while cell contents stay undefined until written.
// A stalled response register holds the apply cycle until it is taken, but
// a new request is accepted while an earlier response is still waiting.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete import slid_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   slid_req_if.sink   req_ch,
   slid_rsp_if.source rsp_ch
);

   // The count must hold DEPTH itself, so it is sized for DEPTH + 1 values.
   localparam int COUNT_W = $clog2(DEPTH + 1);

   slid_state_type state_ff, state_in;

   logic                      req_type_ff, req_type_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]        count_ff, count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic [FIELD_W-1:0]        position_ff, position_in;
   logic [FIELD_W-1:0]        occupancy_ff, occupancy_in;

   logic                      cmp_en;
   logic                      apply_go;
   slid_shift_type            shift;

   logic signed [VALUE_W-1:0] entry_w      [DEPTH];
   logic signed [VALUE_W-1:0] entry_left_w [DEPTH];
   logic signed [VALUE_W-1:0] entry_right_w[DEPTH];
   logic [DEPTH-1:0]          less_w;
   logic [DEPTH-1:0]          less_left_w;
   logic [DEPTH-1:0]          boundary_w;
   logic [DEPTH-1:0]          hit_w;

   logic [COUNT_W-1:0]        pos;
   logic                      full;
   logic                      found;

   // ------------------------------------------------------------------------
   // Row of cells. Cell 0 sees an always-less left neighbor so it becomes the
   // boundary when no entry is below the value; the last cell keeps its own
   // entry on a delete, since that slot falls out of the occupied range.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign less_left_w[i]  = 1'b1;
         assign entry_left_w[i] = value_ff;
      end else begin : g_rest
         assign less_left_w[i]  = less_w[i-1];
         assign entry_left_w[i] = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign entry_right_w[i] = entry_w[i];
      end else begin : g_inner
         assign entry_right_w[i] = entry_w[i+1];
      end

      slid_cell #(
         .IDX     (i),
         .COUNT_W (COUNT_W)
      ) u_cell (
         .clock       (clock),
         .cmp_en      (cmp_en),
         .shift       (shift),
         .value       (value_ff),
         .count       (count_ff),
         .less_left   (less_left_w[i]),
         .entry_left  (entry_left_w[i]),
         .entry_right (entry_right_w[i]),
         .entry       (entry_w[i]),
         .less        (less_w[i]),
         .boundary    (boundary_w[i]),
         .hit         (hit_w[i])
      );
   end

   // ------------------------------------------------------------------------
   // Position encode. Exactly one cell is the boundary unless every cell is
   // occupied and below the value, in which case the position is DEPTH.
   // ------------------------------------------------------------------------
   always_comb begin
      pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (boundary_w[i]) begin
            pos = pos | COUNT_W'(i);
         end
      end
      if (less_w[DEPTH-1]) begin
         pos = COUNT_W'(DEPTH);
      end
   end

   assign full  = (count_ff == COUNT_W'(DEPTH));
   assign found = |hit_w;

   // ------------------------------------------------------------------------
   // Control: accept, compare, apply. The apply step waits only while the
   // response register still holds a result nobody has taken.
   // ------------------------------------------------------------------------
   assign apply_go     = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_ch.ready);
   assign cmp_en       = (state_ff == S_COMPARE);
   assign req_ch.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      req_type_in  = req_type_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      position_in  = position_ff;
      occupancy_in = occupancy_ff;
      shift        = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               req_type_in = req_ch.req_type;
               value_in    = req_ch.value;
               state_in    = S_COMPARE;
            end
         end
         S_COMPARE: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (apply_go) begin
               priority if (req_type_ff == OP_INSERT && full) begin
                  status_in = ST_FULL;
               end else if (req_type_ff == OP_INSERT) begin
                  shift.ins = 1'b1;
                  count_in  = count_ff + COUNT_W'(1);
                  status_in = ST_INSERTED;
               end else if (found) begin
                  shift.del = 1'b1;
                  count_in  = count_ff - COUNT_W'(1);
                  status_in = ST_DELETED;
               end else begin
                  status_in = ST_NOT_FOUND;
               end
               position_in  = FIELD_W'(pos);
               occupancy_in = FIELD_W'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      position_ff  <= position_in;
      occupancy_ff <= occupancy_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.position  = position_ff;
   assign rsp_ch.occupancy = occupancy_ff;

endmodule

// ----- hw/rtl/slid_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry, compares it to the broadcast value and shifts with its
// neighbors on insert or delete.
// ----------------------------------------------------------------------------
module slid_cell import slid_pkg::*; #(
   parameter int IDX     = 0,
   parameter int COUNT_W = 7
) (
   input  logic                      clock,
   input  logic                      cmp_en,
   input  slid_shift_type            shift,
   input  logic signed [VALUE_W-1:0] value,
   input  logic [COUNT_W-1:0]        count,
   input  logic                      less_left,
   input  logic signed [VALUE_W-1:0] entry_left,
   input  logic signed [VALUE_W-1:0] entry_right,
   output logic signed [VALUE_W-1:0] entry,
   output logic                      less,
   output logic                      boundary,
   output logic                      hit
);

   logic signed [VALUE_W-1:0] entry_ff, entry_in;
   logic                      less_ff, less_in;
   logic                      eq_ff, eq_in;
   logic                      occupied;

   assign occupied = (COUNT_W'(IDX) < count);

   // The first cell whose entry is not below the value marks the position.
   assign boundary = !less_ff && less_left;
   assign hit      = boundary && eq_ff;

   always_comb begin
      less_in  = less_ff;
      eq_in    = eq_ff;
      entry_in = entry_ff;
      if (cmp_en) begin
         less_in = occupied && (entry_ff < value);
         eq_in   = occupied && (entry_ff == value);
      end
      if (shift.ins && !less_ff) begin
         entry_in = boundary ? value : entry_left;
      end else if (shift.del && !less_ff) begin
         entry_in = entry_right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      less_ff  <= less_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign less  = less_ff;

endmodule
